// ===== rtl/tjfs_pkg.sv =====
`timescale 1ns / 1ps

package tjfs_pkg;

   // Positions and limits: signed Q16.16
   typedef logic signed [31:0] pos_type;
   // Speeds and periods: unsigned Q8.16
   typedef logic [23:0] rate_type;
   // Mimic ratio: unsigned Q4.16
   typedef logic [19:0] ratio_type;
   // Step size: (period * rate) >> 16
   typedef logic [31:0] step_type;
   typedef logic [2:0]  status_type;
   typedef logic [2:0]  csr_index_type;
   typedef logic [31:0] csr_data_type;

   // Result status codes
   localparam status_type ST_NONE       = 3'd0;
   localparam status_type ST_DIST_HIT   = 3'd1;
   localparam status_type ST_DIST_LIMIT = 3'd2;
   localparam status_type ST_PROX_GOAL  = 3'd3;
   localparam status_type ST_REJECT     = 3'd4;

   // Input word modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   // Register indexes
   localparam csr_index_type REG_PROXIMAL_LOW  = 3'd0;
   localparam csr_index_type REG_PROXIMAL_HIGH = 3'd1;
   localparam csr_index_type REG_DISTAL_LOW    = 3'd2;
   localparam csr_index_type REG_DISTAL_HIGH   = 3'd3;
   localparam csr_index_type REG_PROXIMAL_RATE = 3'd4;
   localparam csr_index_type REG_DISTAL_RATE   = 3'd5;
   localparam csr_index_type REG_MIMIC_RATIO   = 3'd6;

   // Register reset values
   localparam pos_type   PROXIMAL_LOW_RST  = 32'sd0;
   localparam pos_type   PROXIMAL_HIGH_RST = 32'sd160000;
   localparam pos_type   DISTAL_LOW_RST    = 32'sd0;
   localparam pos_type   DISTAL_HIGH_RST   = 32'sd55000;
   localparam rate_type  PROXIMAL_RATE_RST = 24'd65536;
   localparam rate_type  DISTAL_RATE_RST   = 24'd65536;
   localparam ratio_type MIMIC_RATIO_RST   = 20'd21845;

   typedef struct packed {
      pos_type   proximal_low;
      pos_type   proximal_high;
      pos_type   distal_low;
      pos_type   distal_high;
      rate_type  proximal_rate;
      rate_type  distal_rate;
      ratio_type mimic_ratio;
   } cfg_type;

   // Registered input word, with step sizes and clamped goal worked out
   typedef struct packed {
      logic     mode;
      pos_type  goal;
      step_type distal_step;
      step_type proximal_step;
      logic     distal_hit;
      logic     proximal_hit;
   } item_type;

   // Saturate a wide signed value to the 32-bit position range
   function automatic pos_type sat_pos(input logic signed [36:0] v);
      logic signed [36:0] max_v;
      logic signed [36:0] min_v;
      max_v = 37'sh0_7FFF_FFFF;
      min_v = -37'sh0_8000_0000;
      if (v > max_v) begin
         sat_pos = 32'sh7FFF_FFFF;
      end else if (v < min_v) begin
         sat_pos = 32'sh8000_0000;
      end else begin
         sat_pos = v[31:0];
      end
   endfunction

endpackage

// ===== rtl/tjfs_req_if.sv =====
`timescale 1ns / 1ps

interface tjfs_req_if;
   import tjfs_pkg::*;

   logic     valid;
   logic     ready;
   logic     mode;
   pos_type  goal;
   rate_type period;
   logic     distal_hit;
   logic     proximal_hit;

   modport source (output valid, mode, goal, period, distal_hit, proximal_hit,
                   input ready);
   modport sink   (input valid, mode, goal, period, distal_hit, proximal_hit,
                   output ready);
endinterface

// ===== rtl/tjfs_rsp_if.sv =====
`timescale 1ns / 1ps

interface tjfs_rsp_if;
   import tjfs_pkg::*;

   logic       valid;
   logic       ready;
   pos_type    proximal_position;
   pos_type    distal_position;
   logic       busy_res;
   status_type status;

   modport source (output valid, proximal_position, distal_position, busy_res, status,
                   input ready);
   modport sink   (input valid, proximal_position, distal_position, busy_res, status,
                   output ready);
endinterface

// ===== rtl/tjfs_csr.sv =====
`timescale 1ns / 1ps

module tjfs_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  tjfs_pkg::csr_index_type csr_index,
   input  tjfs_pkg::csr_data_type  csr_data,
   output tjfs_pkg::cfg_type       cfg
);
   import tjfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_PROXIMAL_LOW:  cfg_in.proximal_low  = csr_data;
            REG_PROXIMAL_HIGH: cfg_in.proximal_high = csr_data;
            REG_DISTAL_LOW:    cfg_in.distal_low    = csr_data;
            REG_DISTAL_HIGH:   cfg_in.distal_high   = csr_data;
            REG_PROXIMAL_RATE: cfg_in.proximal_rate = csr_data[23:0];
            REG_DISTAL_RATE:   cfg_in.distal_rate   = csr_data[23:0];
            REG_MIMIC_RATIO:   cfg_in.mimic_ratio   = csr_data[19:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.proximal_low  <= PROXIMAL_LOW_RST;
         cfg_ff.proximal_high <= PROXIMAL_HIGH_RST;
         cfg_ff.distal_low    <= DISTAL_LOW_RST;
         cfg_ff.distal_high   <= DISTAL_HIGH_RST;
         cfg_ff.proximal_rate <= PROXIMAL_RATE_RST;
         cfg_ff.distal_rate   <= DISTAL_RATE_RST;
         cfg_ff.mimic_ratio   <= MIMIC_RATIO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/tjfs_intake.sv =====
`timescale 1ns / 1ps

module tjfs_intake (
   input  logic               clock,
   input  logic               reset,
   tjfs_req_if.sink           req_chan,
   input  tjfs_pkg::cfg_type  cfg,
   input  logic               take,
   output logic               item_valid,
   output tjfs_pkg::item_type item
);
   import tjfs_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   item_type       item_ff;
   item_type       item_in;
   logic           accept;
   logic [47:0]    distal_prod;
   logic [47:0]    proximal_prod;
   pos_type        goal_clamped;

   // Take a new word when the stage is empty or its word moves on
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   // Step sizes: period times speed, drop the 16 fraction bits
   assign distal_prod   = 48'(req_chan.period) * 48'(cfg.distal_rate);
   assign proximal_prod = 48'(req_chan.period) * 48'(cfg.proximal_rate);

   // Clamp the goal, lower limit first
   always_comb begin
      priority if (req_chan.goal < cfg.proximal_low) begin
         goal_clamped = cfg.proximal_low;
      end else if (req_chan.goal > cfg.proximal_high) begin
         goal_clamped = cfg.proximal_high;
      end else begin
         goal_clamped = req_chan.goal;
      end
   end

   always_comb begin
      item_in.mode          = req_chan.mode;
      item_in.goal          = goal_clamped;
      item_in.distal_step   = distal_prod[47:16];
      item_in.proximal_step = proximal_prod[47:16];
      item_in.distal_hit    = req_chan.distal_hit;
      item_in.proximal_hit  = req_chan.proximal_hit;
   end

   // Hold the word until the core takes it
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/tjfs_core.sv =====
`timescale 1ns / 1ps

module tjfs_core (
   input  logic               clock,
   input  logic               reset,
   input  tjfs_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  tjfs_pkg::item_type item,
   output logic               take,
   tjfs_rsp_if.source         rsp_chan
);
   import tjfs_pkg::*;

   // Joint state
   pos_type ppos_ff, ppos_in;
   pos_type dpos_ff, dpos_in;
   pos_type ptarget_ff, ptarget_in;
   pos_type dtarget_ff, dtarget_in;
   logic    moving_ff, moving_in;
   logic    donly_ff, donly_in;

   // Result register
   logic       out_valid_ff, out_valid_in;
   status_type status_in;
   status_type status_ff;
   pos_type    out_ppos_ff;
   pos_type    out_dpos_ff;
   logic       out_busy_ff;

   logic signed [52:0] mimic_prod;
   logic signed [33:0] dpos_ext, ppos_ext, dstep_ext, pstep_ext;
   logic signed [33:0] dhigh_ext, dlow_ext, dtarget_ext, ptarget_ext;
   logic signed [33:0] nd, np;
   logic               up;
   logic               dlimit;
   logic               pgoal;

   // Move the word on when the result register is free or being emptied
   assign take = item_valid && (!out_valid_ff || rsp_chan.ready);

   assign mimic_prod = 53'(item.goal) * 53'($signed({1'b0, cfg.mimic_ratio}));

   assign dpos_ext    = {{2{dpos_ff[31]}}, dpos_ff};
   assign ppos_ext    = {{2{ppos_ff[31]}}, ppos_ff};
   assign dstep_ext   = $signed({2'b00, item.distal_step});
   assign pstep_ext   = $signed({2'b00, item.proximal_step});
   assign dhigh_ext   = {{2{cfg.distal_high[31]}}, cfg.distal_high};
   assign dlow_ext    = {{2{cfg.distal_low[31]}}, cfg.distal_low};
   assign dtarget_ext = {{2{dtarget_ff[31]}}, dtarget_ff};
   assign ptarget_ext = {{2{ptarget_ff[31]}}, ptarget_ff};
   assign up          = ppos_ff < ptarget_ff;

   // Distal step toward goal or limit
   always_comb begin
      dlimit = 1'b0;
      if (up) begin
         nd = dpos_ext + dstep_ext;
         if (dhigh_ext <= nd) begin
            nd     = dhigh_ext;
            dlimit = 1'b1;
         end
         if (!donly_ff && dtarget_ext <= nd) begin
            nd = dtarget_ext;
         end
      end else begin
         nd = dpos_ext - dstep_ext;
         if (dlow_ext >= nd) begin
            nd     = dlow_ext;
            dlimit = 1'b1;
         end
         if (!donly_ff && dtarget_ext >= nd) begin
            nd = dtarget_ext;
         end
      end
   end

   // Proximal step and goal check
   always_comb begin
      if (up) begin
         np    = ppos_ext + pstep_ext;
         pgoal = ptarget_ext <= np;
      end else begin
         np    = ppos_ext - pstep_ext;
         pgoal = ptarget_ext >= np;
      end
   end

   // Apply one word to the state
   always_comb begin
      ppos_in    = ppos_ff;
      dpos_in    = dpos_ff;
      ptarget_in = ptarget_ff;
      dtarget_in = dtarget_ff;
      moving_in  = moving_ff;
      donly_in   = donly_ff;
      status_in  = ST_NONE;
      if (item.mode == MODE_START) begin
         if (moving_ff) begin
            status_in = ST_REJECT;
         end else begin
            ptarget_in = item.goal;
            dtarget_in = sat_pos(mimic_prod[52:16]);
            donly_in   = 1'b0;
            moving_in  = 1'b1;
         end
      end else if (moving_ff) begin
         if (item.distal_hit) begin
            moving_in = 1'b0;
            status_in = ST_DIST_HIT;
         end else begin
            dpos_in = sat_pos({{3{nd[33]}}, nd});
            if (dlimit) begin
               moving_in = 1'b0;
               status_in = ST_DIST_LIMIT;
            end else if (donly_ff) begin
               status_in = ST_NONE;
            end else if (item.proximal_hit) begin
               donly_in = 1'b1;
            end else if (pgoal) begin
               ppos_in   = ptarget_ff;
               moving_in = 1'b0;
               status_in = ST_PROX_GOAL;
            end else begin
               ppos_in = sat_pos({{3{np[33]}}, np});
            end
         end
      end
   end

   always_comb begin
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Update state and result on each taken word
   always_ff @(posedge clock) begin
      if (reset) begin
         ppos_ff      <= '0;
         dpos_ff      <= '0;
         ptarget_ff   <= '0;
         dtarget_ff   <= '0;
         moving_ff    <= 1'b0;
         donly_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            ppos_ff    <= ppos_in;
            dpos_ff    <= dpos_in;
            ptarget_ff <= ptarget_in;
            dtarget_ff <= dtarget_in;
            moving_ff  <= moving_in;
            donly_ff   <= donly_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ppos_ff <= ppos_in;
         out_dpos_ff <= dpos_in;
         out_busy_ff <= moving_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.proximal_position = out_ppos_ff;
   assign rsp_chan.distal_position   = out_dpos_ff;
   assign rsp_chan.busy_res          = out_busy_ff;
   assign rsp_chan.status            = status_ff;

endmodule

// ===== rtl/two_joint_finger_position_stepper.sv =====
`timescale 1ns / 1ps

// Two-joint finger position stepper.
// req_chan carries one word per item: a start (mode 0) with a proximal goal, or
// a tick (mode 1) with elapsed period and the two collision flags. rsp_chan
// returns exactly one word per item: both joint positions after the item, the
// busy flag and a status code (none, distal collision, distal limit, proximal
// goal reached, start rejected).
// Limits, speeds and the mimic ratio sit behind the csr_ write port; write them
// only while no item is in flight.
// A word passes through the input register and then the result register. Throughput
// is one word per cycle while the receiver keeps rsp_chan.ready high: the step
// products are formed as a word enters the input register and one pass of compare
// and select logic updates the joint state and the result register as the core takes it.
// Reset clears the joint state, returns the registers to their defaults and
// empties both stages. When the receiver stalls the result word is held and
// the input register still takes one more word before req_chan.ready drops.
module two_joint_finger_position_stepper (
   input  logic                    clock,
   input  logic                    reset,
   tjfs_req_if.sink                req_chan,
   tjfs_rsp_if.source              rsp_chan,
   input  logic                    csr_write,
   input  tjfs_pkg::csr_index_type csr_index,
   input  tjfs_pkg::csr_data_type  csr_data
);
   import tjfs_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     take;

   tjfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tjfs_intake u_intake (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   tjfs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/tjfs_checker.sv =====
`timescale 1ns / 1ps

module tjfs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input tjfs_pkg::pos_type    rsp_proximal_position,
   input logic                rsp_busy_res,
   input tjfs_pkg::status_type rsp_status
);
   import tjfs_pkg::*;

   // A stalled result word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word holds its position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_proximal_position))
      else $error("result position changed while stalled");

   // A fresh result traces back to a word accepted into the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without an accepted item");

   // A rejected start leaves the move busy; an ending status leaves it idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_REJECT |-> rsp_busy_res)
      else $error("start rejected while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DIST_HIT || rsp_status == ST_DIST_LIMIT ||
                    rsp_status == ST_PROX_GOAL) |-> !rsp_busy_res)
      else $error("move still busy after it ended");

endmodule

bind two_joint_finger_position_stepper tjfs_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_chan.valid),
   .req_ready             (req_chan.ready),
   .rsp_valid             (rsp_chan.valid),
   .rsp_ready             (rsp_chan.ready),
   .rsp_proximal_position (rsp_chan.proximal_position),
   .rsp_busy_res          (rsp_chan.busy_res),
   .rsp_status            (rsp_chan.status)
);
